>>> rtl/vole_cpu_step_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Vole CPU step block
// Concurrent checks sampled on clk and switched off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef VOLE_CPU_STEP_TOP_ASSERT_SVH
`define VOLE_CPU_STEP_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VCPU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VCPU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/vcpu_pkg.sv
// ----------------------------------------------------------------------------
// Vole CPU step package
// Sizes, request codes, opcodes and sequencer states of the Vole CPU block.
// ----------------------------------------------------------------------------
package vcpu_pkg;

	localparam int MEM_DEPTH = 256;
	localparam int REG_COUNT = 16;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);
	localparam int REG_AW    = $clog2(REG_COUNT);

	typedef enum logic [1:0] {
		CMD_WR_MEM = 2'd0,
		CMD_RD_MEM = 2'd1,
		CMD_RD_REG = 2'd2,
		CMD_EXEC   = 2'd3
	} vcpu_cmd_t;

	localparam logic [3:0] OP_LOAD  = 4'h1;
	localparam logic [3:0] OP_IMM   = 4'h2;
	localparam logic [3:0] OP_STORE = 4'h3;
	localparam logic [3:0] OP_MOVE  = 4'h4;
	localparam logic [3:0] OP_ADD   = 4'h5;
	localparam logic [3:0] OP_JEQ   = 4'hB;
	localparam logic [3:0] OP_HALT  = 4'hC;

	localparam logic [REG_AW-1:0] REG_ZERO = '0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_RD_MEM,
		ST_RD_REG,
		ST_FETCH_HI,
		ST_FETCH_LO,
		ST_LOAD_MEM,
		ST_STORE,
		ST_MOVE,
		ST_ADD_X,
		ST_ADD_Y,
		ST_JMP_R,
		ST_JMP_0,
		ST_DONE
	} vcpu_state_t;

endpackage

>>> rtl/vcpu_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle, read data registered.
// ----------------------------------------------------------------------------
module vcpu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> rtl/vole_cpu_step_top.sv
// ----------------------------------------------------------------------------
// Vole CPU step block
// A small byte-wide CPU driven one request at a time over a stream port.
//
// Requests enter on s_tvalid/s_tready: s_tuser carries the command (write
// memory byte, read memory byte, read register, execute one instruction),
// s_tdata the address and the write byte. Each request gives exactly one
// response on m_tvalid/m_tready with the byte read, the program counter,
// the last fetched instruction and the halted and bad-instruction flags.
// Main memory and the register file are single-port RAMs with a registered
// read, and the sequencer makes one access to each per cycle. After a
// dispatch state, a memory write or a halted execute goes straight to the
// done state, a read passes one read state, and an instruction passes
// two fetch reads, then up to two register reads or one operand read and
// a write-back. The next request is taken once the response has moved into
// the output register. A finished response waits in the output
// register while the receiver stalls; a new request is still accepted then
// and its own response holds until the register is free. Reset clears the
// counter, instruction, halt flag and every stored byte (through per-entry
// valid bits) at once; no clearing pass follows it.
// ----------------------------------------------------------------------------
`include "vole_cpu_step_top_assert.svh"

module vole_cpu_step_top
	import vcpu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [7:0] address, [15:8] write_data
	input  logic [1:0]  s_tuser,  // [1:0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [7:0] read_data, [15:8] pc_value, [31:16] instruction_word
	output logic [1:0]  m_tuser   // [0] halted, [1] bad_instruction
);

	vcpu_state_t state_q, state_d;

	vcpu_cmd_t         cmd_q;
	logic [MEM_AW-1:0] addr_q;
	logic [7:0]        wdata_q;
	logic [MEM_AW-1:0] pc_q;
	logic [15:0]       ir_q;
	logic              halt_q;
	logic              bad_q;
	logic [7:0]        hi_q;
	logic [7:0]        opa_q;
	logic [7:0]        rdata_q;

	logic [MEM_DEPTH-1:0] mem_valid_q;
	logic [REG_COUNT-1:0] reg_valid_q;
	logic                 mem_rvalid_s1;
	logic                 reg_rvalid_s1;

	logic              m_tvalid_q;
	logic [31:0]       m_tdata_q;
	logic [1:0]        m_tuser_q;

	logic [MEM_AW-1:0] mem_addr;
	logic              mem_we;
	logic [7:0]        mem_wdata;
	logic [7:0]        mem_rdata;
	logic [7:0]        mem_val;
	logic [REG_AW-1:0] reg_addr;
	logic              reg_we;
	logic [7:0]        reg_wdata;
	logic [7:0]        reg_rdata;
	logic [7:0]        reg_val;

	logic              s_fire;
	logic              done_fire;
	logic [3:0]        op;
	logic              op_known;

	vcpu_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	vcpu_ram #(.WIDTH(8), .DEPTH(REG_COUNT)) u_regs (
		.clk   (clk),
		.we    (reg_we),
		.addr  (reg_addr),
		.wdata (reg_wdata),
		.rdata (reg_rdata)
	);

	// An entry never written since reset reads as zero.
	assign mem_val = mem_rvalid_s1 ? mem_rdata : 8'd0;
	assign reg_val = reg_rvalid_s1 ? reg_rdata : 8'd0;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_fire    = s_tvalid && s_tready;
	assign done_fire = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// During the low-byte fetch the opcode comes from the high byte held in hi_q.
	assign op = hi_q[7:4];

	always_comb begin
		case (op)
			OP_LOAD, OP_IMM, OP_STORE, OP_MOVE, OP_ADD, OP_JEQ, OP_HALT: op_known = 1'b1;
			default: op_known = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_fire) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				case (cmd_q)
					CMD_WR_MEM: state_d = ST_DONE;
					CMD_RD_MEM: state_d = ST_RD_MEM;
					CMD_RD_REG: state_d = ST_RD_REG;
					CMD_EXEC:   state_d = halt_q ? ST_DONE : ST_FETCH_HI;
					default:    state_d = ST_DONE;
				endcase
			end
			ST_RD_MEM:   state_d = ST_DONE;
			ST_RD_REG:   state_d = ST_DONE;
			ST_FETCH_HI: state_d = ST_FETCH_LO;
			ST_FETCH_LO: begin
				case (op)
					OP_LOAD:  state_d = ST_LOAD_MEM;
					OP_STORE: state_d = ST_STORE;
					OP_MOVE:  state_d = ST_MOVE;
					OP_ADD:   state_d = ST_ADD_X;
					OP_JEQ:   state_d = ST_JMP_R;
					default:  state_d = ST_DONE;
				endcase
			end
			ST_LOAD_MEM: state_d = ST_DONE;
			ST_STORE:    state_d = ST_DONE;
			ST_MOVE:     state_d = ST_DONE;
			ST_ADD_X:    state_d = ST_ADD_Y;
			ST_ADD_Y:    state_d = ST_DONE;
			ST_JMP_R:    state_d = ST_JMP_0;
			ST_JMP_0:    state_d = ST_DONE;
			ST_DONE: begin
				if (done_fire) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_addr  = pc_q;
		mem_we    = 1'b0;
		mem_wdata = wdata_q;
		reg_addr  = hi_q[3:0];
		reg_we    = 1'b0;
		reg_wdata = mem_val;
		case (state_q)
			ST_DISPATCH: begin
				case (cmd_q)
					CMD_WR_MEM: begin
						mem_addr = addr_q;
						mem_we   = 1'b1;
					end
					CMD_RD_MEM: mem_addr = addr_q;
					CMD_RD_REG: reg_addr = addr_q[REG_AW-1:0];
					CMD_EXEC:   mem_addr = pc_q;
					default:    mem_addr = pc_q;
				endcase
			end
			ST_FETCH_HI: mem_addr = pc_q + MEM_AW'(1);
			ST_FETCH_LO: begin
				case (op)
					OP_LOAD: mem_addr = mem_val;
					OP_IMM: begin
						reg_we    = 1'b1;
						reg_wdata = mem_val;
					end
					OP_MOVE, OP_ADD: reg_addr = mem_val[7:4];
					default: reg_addr = hi_q[3:0];
				endcase
			end
			ST_LOAD_MEM: begin
				reg_addr  = ir_q[11:8];
				reg_we    = 1'b1;
				reg_wdata = mem_val;
			end
			ST_STORE: begin
				mem_addr  = ir_q[7:0];
				mem_we    = 1'b1;
				mem_wdata = reg_val;
			end
			ST_MOVE: begin
				reg_addr  = ir_q[3:0];
				reg_we    = 1'b1;
				reg_wdata = reg_val;
			end
			ST_ADD_X: reg_addr = ir_q[3:0];
			ST_ADD_Y: begin
				reg_addr  = ir_q[11:8];
				reg_we    = 1'b1;
				reg_wdata = opa_q + reg_val;
			end
			ST_JMP_R: reg_addr = REG_ZERO;
			default: begin
				mem_we = 1'b0;
				reg_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mem_valid_q   <= '0;
			reg_valid_q   <= '0;
			mem_rvalid_s1 <= 1'b0;
			reg_rvalid_s1 <= 1'b0;
			pc_q          <= '0;
			ir_q          <= '0;
			halt_q        <= 1'b0;
			bad_q         <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q       <= state_d;
			mem_rvalid_s1 <= mem_valid_q[mem_addr];
			reg_rvalid_s1 <= reg_valid_q[reg_addr];
			if (mem_we) mem_valid_q[mem_addr] <= 1'b1;
			if (reg_we) reg_valid_q[reg_addr] <= 1'b1;
			case (state_q)
				ST_DISPATCH: bad_q <= 1'b0;
				ST_FETCH_LO: begin
					ir_q  <= {hi_q, mem_val};
					pc_q  <= pc_q + MEM_AW'(2);
					bad_q <= !op_known;
					if (op == OP_HALT) halt_q <= 1'b1;
				end
				ST_JMP_0: begin
					if (opa_q == reg_val) pc_q <= ir_q[7:0];
				end
				default: bad_q <= bad_q;
			endcase
			if (done_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_q   <= vcpu_cmd_t'(s_tuser);
			addr_q  <= s_tdata[7:0];
			wdata_q <= s_tdata[15:8];
		end
		case (state_q)
			ST_DISPATCH: rdata_q <= 8'd0;
			ST_RD_MEM:   rdata_q <= mem_val;
			ST_RD_REG:   rdata_q <= reg_val;
			ST_FETCH_HI: hi_q    <= mem_val;
			ST_ADD_X:    opa_q   <= reg_val;
			ST_JMP_R:    opa_q   <= reg_val;
			default:     opa_q   <= opa_q;
		endcase
		if (done_fire) begin
			m_tdata_q <= {ir_q, pc_q, rdata_q};
			m_tuser_q <= {bad_q, halt_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`VCPU_ASSERT_NEXT(a_halt_sticky, halt_q, halt_q, "halt flag cleared after being set")
	`VCPU_ASSERT_NEXT(a_pc_only_on_exec, !(state_q == ST_FETCH_LO || state_q == ST_JMP_0), $stable(pc_q), "program counter moved outside fetch or jump")
	`VCPU_ASSERT_NOW(a_bad_not_halted, m_tvalid_q && m_tuser_q[1], !m_tuser_q[0] || ir_q[15:12] != OP_HALT, "bad instruction reported for a halt")
	`VCPU_ASSERT_NOW(a_one_write, mem_we, !reg_we && (state_q == ST_DISPATCH || state_q == ST_STORE), "memory written outside a write request or store")

endmodule

>>> verif/tb_vole_cpu_step_top.sv
// ----------------------------------------------------------------------------
// Testbench for the Vole CPU step block
// Drives memory, register and execute requests over the input stream and
// checks every response against a cycle-free model of the CPU that runs in
// step with the accepted requests. Directed programs come first, then random
// programs under several idling patterns, a long output hold-off, and the
// halt instruction at the very end because the halt flag is sticky.
// ----------------------------------------------------------------------------
module tb_vole_cpu_step_top;
	import vcpu_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 3000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [7:0]  pc_value;
		logic [15:0] instr_word;
		logic        halted;
		logic        bad_instr;
	} step_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	// CPU model state, updated as each request is accepted.
	logic [7:0]  mem_image [MEM_DEPTH];
	logic [7:0]  reg_image [REG_COUNT];
	logic [7:0]  pc_image = '0;
	logic [15:0] ir_image = '0;
	logic        halt_image = 1'b0;

	step_result_t pending_results [$];
	logic [15:0]  program_words [$];

	int  error_count = 0;
	int  requests_sent = 0;
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  quiet_cycles = 0;
	int  hold_left = 0;
	int  hold_len = 0;
	bit  hold_go = 1'b0;
	bit  halt_allowed = 1'b0;

	vole_cpu_step_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #6 clk = ~clk;

	initial begin
		foreach (mem_image[i]) mem_image[i] = '0;
		foreach (reg_image[i]) reg_image[i] = '0;
	end

	function automatic step_result_t cpu_predict(input vcpu_cmd_t cmd, input logic [7:0] addr,
			input logic [7:0] wdata);
		step_result_t res;
		logic [7:0]   hi;
		logic [7:0]   lo;
		logic [7:0]   next_addr;
		res = '0;
		case (cmd)
			CMD_WR_MEM: mem_image[addr] = wdata;
			CMD_RD_MEM: res.read_data = mem_image[addr];
			CMD_RD_REG: res.read_data = reg_image[addr[3:0]];
			default: begin
				if (!halt_image) begin
					next_addr = pc_image + 8'd1;
					hi = mem_image[pc_image];
					lo = mem_image[next_addr];
					ir_image = {hi, lo};
					pc_image = pc_image + 8'd2;
					case (hi[7:4])
						OP_LOAD:  reg_image[hi[3:0]] = mem_image[lo];
						OP_IMM:   reg_image[hi[3:0]] = lo;
						OP_STORE: mem_image[lo] = reg_image[hi[3:0]];
						OP_MOVE:  reg_image[lo[3:0]] = reg_image[lo[7:4]];
						OP_ADD:   reg_image[hi[3:0]] = reg_image[lo[7:4]] + reg_image[lo[3:0]];
						OP_JEQ: begin
							if (reg_image[hi[3:0]] == reg_image[REG_ZERO])
								pc_image = lo;
						end
						OP_HALT:  halt_image = 1'b1;
						default:  res.bad_instr = 1'b1;
					endcase
				end
			end
		endcase
		res.pc_value = pc_image;
		res.instr_word = ir_image;
		res.halted = halt_image;
		return res;
	endfunction

	// Any instruction but halt; an unsupported opcode about a quarter of the time.
	function automatic logic [15:0] random_instruction();
		logic [3:0] op;
		logic [3:0] r;
		logic [7:0] lo;
		r = 4'($urandom_range(15));
		lo = 8'($urandom_range(255));
		case ($urandom_range(7))
			0: op = OP_LOAD;
			1: op = OP_IMM;
			2: op = OP_STORE;
			3: op = OP_MOVE;
			4: op = OP_ADD;
			5: begin
				op = OP_JEQ;
				if ($urandom_range(2) == 0)
					r = REG_ZERO;
			end
			default: begin
				do
					op = 4'($urandom_range(15));
				while (op == OP_LOAD || op == OP_IMM || op == OP_STORE || op == OP_MOVE ||
						op == OP_ADD || op == OP_JEQ || op == OP_HALT);
			end
		endcase
		return {op, r, lo};
	endfunction

	task automatic send_request(input vcpu_cmd_t cmd, input logic [7:0] addr,
			input logic [7:0] wdata);
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {wdata, addr};
		// Inputs only move at the rising edge, so ready seen mid-cycle decides the request.
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		pending_results.push_back(cpu_predict(cmd, addr, wdata));
		requests_sent++;
	endtask

	// Until the halt test, a halt word found at the counter has its high byte overwritten first.
	task automatic execute_step();
		logic [15:0] patch;
		if (!halt_allowed && mem_image[pc_image][7:4] == OP_HALT) begin
			patch = random_instruction();
			send_request(CMD_WR_MEM, pc_image, patch[15:8]);
		end
		send_request(CMD_EXEC, 8'($urandom_range(255)), 8'($urandom_range(255)));
	endtask

	task automatic store_program();
		logic [7:0] base;
		base = pc_image;
		foreach (program_words[i]) begin
			send_request(CMD_WR_MEM, base + 8'(2 * i), program_words[i][15:8]);
			send_request(CMD_WR_MEM, base + 8'(2 * i + 1), program_words[i][7:0]);
		end
	endtask

	task automatic random_request();
		vcpu_cmd_t cmd;
		cmd = vcpu_cmd_t'($urandom_range(3));
		if (cmd == CMD_EXEC)
			execute_step();
		else
			send_request(cmd, 8'($urandom_range(255)), 8'($urandom_range(255)));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	task automatic test_memory_access();
		send_request(CMD_WR_MEM, 8'hFF, 8'hA5);
		send_request(CMD_WR_MEM, 8'h80, 8'hFF);
		send_request(CMD_RD_MEM, 8'hFF, 8'h00);
		send_request(CMD_RD_MEM, 8'h80, 8'hFF);
		send_request(CMD_RD_MEM, 8'h00, 8'h00);
		send_request(CMD_RD_REG, 8'hFF, 8'h00);
	endtask

	// Overflowing add, move with a non-zero ignored nibble, store and load at the top
	// address, a jump not taken, and an unconditional jump to the last byte whose
	// fetch wraps round to address zero and meets an unsupported opcode.
	task automatic test_instruction_set();
		program_words = {
			{OP_IMM,   4'h1,     8'hFF},
			{OP_ADD,   4'h2,     8'h11},
			{OP_MOVE,  4'hF,     8'h13},
			{OP_STORE, 4'h1,     8'hFF},
			{OP_LOAD,  4'h4,     8'hFF},
			{OP_JEQ,   4'h1,     8'h00},
			{OP_JEQ,   REG_ZERO, 8'hFF}
		};
		store_program();
		repeat (9) execute_step();
		send_request(CMD_RD_REG, 8'h02, 8'h00);
		send_request(CMD_RD_REG, 8'hF4, 8'h00);
		send_request(CMD_RD_REG, 8'h03, 8'h00);
	endtask

	task automatic test_random_programs(input int count);
		int stop_at;
		int len;
		stop_at = requests_sent + count;
		while (requests_sent < stop_at) begin
			if ($urandom_range(4) == 0) begin
				random_request();
			end else begin
				len = $urandom_range(1, 5);
				program_words.delete();
				repeat (len) program_words.push_back(random_instruction());
				store_program();
				if ($urandom_range(3) == 0)
					send_request(CMD_RD_REG, 8'($urandom_range(255)), 8'($urandom_range(255)));
				repeat (len) execute_step();
				repeat ($urandom_range(2))
					send_request(vcpu_cmd_t'($urandom_range(1, 2)), 8'($urandom_range(255)),
						8'($urandom_range(255)));
			end
		end
	endtask

	// The output is held off long enough for the block to stop taking requests.
	task automatic test_back_pressure();
		set_idling(0, 0);
		hold_len = 300;
		hold_go = 1'b1;
		repeat (24) random_request();
		wait_drained();
		test_random_programs(40);
		wait_drained();
	endtask

	task automatic test_halt();
		set_idling(0, 7);
		halt_allowed = 1'b1;
		program_words = {{OP_HALT, 12'h000}};
		store_program();
		repeat (3) execute_step();
		send_request(CMD_WR_MEM, 8'h5A, 8'hC3);
		send_request(CMD_RD_MEM, 8'h5A, 8'h00);
		send_request(CMD_RD_REG, 8'h01, 8'h00);
		repeat (30) random_request();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_memory_access();
		test_instruction_set();
		set_idling(0, 0);
		test_random_programs(400);
		set_idling(71, 0);
		test_random_programs(400);
		set_idling(0, 71);
		test_random_programs(400);
		set_idling(7, 7);
		test_random_programs(400);
		test_back_pressure();
		test_halt();
		wait_drained();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("tb_vole_cpu_step_top: done, clean");
		else
			$display("tb_vole_cpu_step_top: done, errors");
		$finish;
	end

	always @(posedge clk) begin
		if (hold_go) begin
			hold_left = hold_len;
			hold_go = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(negedge clk) begin : check_results
		step_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("unexpected response: tdata %h tuser %b", m_tdata, m_tuser);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[7:0] !== want.read_data || m_tdata[15:8] !== want.pc_value ||
						m_tdata[31:16] !== want.instr_word || m_tuser[0] !== want.halted ||
						m_tuser[1] !== want.bad_instr) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display(
							"mismatch exp/act: read %h/%h pc %h/%h ir %h/%h halt %b/%b bad %b/%b",
							want.read_data, m_tdata[7:0], want.pc_value, m_tdata[15:8],
							want.instr_word, m_tdata[31:16], want.halted, m_tuser[0],
							want.bad_instr, m_tuser[1]);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("tb_vole_cpu_step_top: done, errors");
					$finish;
				end
			end
		end
	end

endmodule
